### hw/rtl/ctab_pkg.sv
// Shared types, codes and helpers for the clipped tint alpha blend pixel unit.
// No dependencies; imported by every module of the block.
package ctab_pkg;

  // Pixel commands carried on in_command.
  typedef enum logic [1:0] {
    CMD_SOLID = 2'd0,
    CMD_TINT  = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CLIP_LEFT    = 3'd0,
    REG_CLIP_TOP     = 3'd1,
    REG_CLIP_WIDTH   = 3'd2,
    REG_CLIP_HEIGHT  = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_TINT_COLOR   = 3'd6,
    REG_SPARE        = 3'd7
  } reg_idx_t;

  localparam int unsigned CH_N     = 4;   // red, green, blue, alpha
  localparam int unsigned WEIGHT_W = 17;  // weight spans 0..65536

  localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = '0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 17'h10000;

  localparam logic signed [15:0] RST_CLIP_LEFT    = 16'sd0;
  localparam logic signed [15:0] RST_CLIP_TOP     = 16'sd0;
  localparam logic signed [15:0] RST_CLIP_WIDTH   = -16'sd1;
  localparam logic signed [15:0] RST_CLIP_HEIGHT  = -16'sd1;
  localparam logic [14:0]        RST_IMAGE_WIDTH  = 15'd640;
  localparam logic [14:0]        RST_IMAGE_HEIGHT = 15'd480;
  localparam logic [31:0]        RST_TINT_COLOR   = 32'hFFFF_FFFF;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_width;
    logic signed [15:0] clip_height;
    logic [14:0]        image_width;
    logic [14:0]        image_height;
    logic [31:0]        tint_color;
  } ctab_cfg_t;

  // Set-up word handed from the front stage to the blend pipe.
  // Channel index 0 is red, 3 is alpha.
  typedef struct packed {
    logic [CH_N-1:0][7:0]  tgt;
    logic [CH_N-1:0][7:0]  dst;
    logic [WEIGHT_W-1:0]   wgt;
    logic                  wr;
  } ctab_pix_t;

  // E(v) = v + (v > 0)
  function automatic logic [8:0] expand8(input logic [7:0] v);
    return {1'b0, v} + {8'd0, |v};
  endfunction

endpackage

### hw/rtl/ctab_front.sv
// First pipeline stage: clip window test, tint scaling and weight products.
// Depends on ctab_pkg.
module ctab_front
  import ctab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctab_cfg_t         cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic signed [15:0] in_dest_x,
  input  logic signed [15:0] in_dest_y,
  input  logic [7:0]        in_src_red,
  input  logic [7:0]        in_src_green,
  input  logic [7:0]        in_src_blue,
  input  logic [7:0]        in_src_alpha,
  input  logic [7:0]        in_dst_red,
  input  logic [7:0]        in_dst_green,
  input  logic [7:0]        in_dst_blue,
  input  logic [7:0]        in_dst_alpha,
  output logic              s1_valid,
  output ctab_pix_t         s1_pix,
  input  logic              s1_ready
);

  logic [15:0]        cw, ch;
  logic signed [17:0] right_edge, bottom_edge, x_ext, y_ext;
  logic               in_win;
  logic [CH_N-1:0][7:0] src, dst;
  logic [8:0]         xs_a, xt_a, w_op;
  logic [17:0]        w_prod;
  logic [2:0][16:0]   tint_prod;
  logic [2:0][7:0]    tint_c;
  cmd_t               cmd;
  ctab_pix_t          pix_nxt, pix_r;
  logic               v_r, v_nxt;

  assign src = {in_src_alpha, in_src_blue, in_src_green, in_src_red};
  assign dst = {in_dst_alpha, in_dst_blue, in_dst_green, in_dst_red};
  assign cmd = cmd_t'(in_command);

  // Negative clip size falls back to the image size.
  assign cw = cfg.clip_width[15]  ? {1'b0, cfg.image_width}  : cfg.clip_width;
  assign ch = cfg.clip_height[15] ? {1'b0, cfg.image_height} : cfg.clip_height;

  assign right_edge  = {{2{cfg.clip_left[15]}}, cfg.clip_left} + $signed({2'b00, cw});
  assign bottom_edge = {{2{cfg.clip_top[15]}}, cfg.clip_top} + $signed({2'b00, ch});
  assign x_ext = {{2{in_dest_x[15]}}, in_dest_x};
  assign y_ext = {{2{in_dest_y[15]}}, in_dest_y};

  assign in_win = (in_dest_x >= cfg.clip_left) && (in_dest_y >= cfg.clip_top) &&
                  (x_ext < right_edge) && (y_ext < bottom_edge);

  // One shared weight multiplier: E(sa)^2 or E(ta)*E(sa).
  assign xs_a   = expand8(in_src_alpha);
  assign xt_a   = expand8(cfg.tint_color[7:0]);
  assign w_op   = (cmd == CMD_SOLID) ? xs_a : xt_a;
  assign w_prod = w_op * xs_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tint_prod[i] = expand8(cfg.tint_color[31-8*i -: 8]) * src[i];
      tint_c[i]    = tint_prod[i][15:8];
    end
  end

  always_comb begin
    pix_nxt.dst = dst;
    pix_nxt.tgt = src;
    pix_nxt.wgt = WEIGHT_ZERO;
    pix_nxt.wr  = 1'b0;
    unique case (cmd)
      CMD_SOLID: begin
        pix_nxt.wgt = w_prod[WEIGHT_W-1:0];
        pix_nxt.wr  = 1'b1;
      end
      CMD_TINT: begin
        pix_nxt.tgt = {src[3], tint_c[2], tint_c[1], tint_c[0]};
        pix_nxt.wgt = w_prod[WEIGHT_W-1:0];
        pix_nxt.wr  = 1'b1;
      end
      // full weight lands exactly on the source
      CMD_COPY: begin
        pix_nxt.wgt = WEIGHT_FULL;
        pix_nxt.wr  = 1'b1;
      end
      default: begin
        pix_nxt.wgt = WEIGHT_ZERO;
        pix_nxt.wr  = 1'b0;
      end
    endcase
    if (!in_win) begin
      pix_nxt.wgt = WEIGHT_ZERO;
      pix_nxt.wr  = 1'b0;
    end
  end

  assign in_ready = !v_r || s1_ready;
  assign v_nxt    = in_ready ? in_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_r <= pix_nxt;
    end
  end

  assign s1_valid = v_r;
  assign s1_pix   = pix_r;

endmodule

### hw/rtl/ctab_blend.sv
// Blend pipe: difference, weighted step, final add (three stages).
// Depends on ctab_pkg.
module ctab_blend
  import ctab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_valid,
  input  ctab_pix_t  s1_pix,
  output logic       s1_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_written
);

  // stage 2: signed difference
  logic                       v2_r;
  logic [CH_N-1:0][8:0]       diff2_r;
  logic [CH_N-1:0][7:0]       dst2_r;
  logic [WEIGHT_W-1:0]        wgt2_r;
  logic                       wr2_r;
  // stage 3: weighted step
  logic                       v3_r;
  logic [CH_N-1:0][7:0]       step3_r;
  logic [CH_N-1:0][7:0]       dst3_r;
  logic                       wr3_r;
  // stage 4: output word
  logic                       v4_r;
  logic [CH_N-1:0][7:0]       pix4_r;
  logic                       wr4_r;

  logic rdy2, rdy3, rdy4;
  logic [CH_N-1:0][8:0]  diff_nxt;
  logic [CH_N-1:0][26:0] prod;
  logic [CH_N-1:0][7:0]  step_nxt, sum_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  always_comb begin
    for (int i = 0; i < CH_N; i++) begin
      diff_nxt[i] = {1'b0, s1_pix.tgt[i]} - {1'b0, s1_pix.dst[i]};
      prod[i]     = $signed({{18{diff2_r[i][8]}}, diff2_r[i]}) *
                    $signed({10'd0, wgt2_r});
      // arithmetic >>16, low eight bits
      step_nxt[i] = prod[i][23:16];
      sum_nxt[i]  = dst3_r[i] + step3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= s1_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      diff2_r <= diff_nxt;
      dst2_r  <= s1_pix.dst;
      wgt2_r  <= s1_pix.wgt;
      wr2_r   <= s1_pix.wr;
    end
    if (rdy3 && v2_r) begin
      step3_r <= step_nxt;
      dst3_r  <= dst2_r;
      wr3_r   <= wr2_r;
    end
    if (rdy4 && v3_r) begin
      pix4_r <= sum_nxt;
      wr4_r  <= wr3_r;
    end
  end

  assign out_valid   = v4_r;
  assign out_red     = pix4_r[0];
  assign out_green   = pix4_r[1];
  assign out_blue    = pix4_r[2];
  assign out_alpha   = pix4_r[3];
  assign out_written = wr4_r;

endmodule

### hw/rtl/clipped_tint_alpha_blend_pixel.sv
// Per-pixel RGBA blend unit with clip window and tint. Each input word carries a
// destination coordinate, a source (or draw) color and the current destination
// pixel; the output word is the new destination pixel plus a written flag. A
// pixel outside the clip window, or command code three, passes the destination
// through with written low. Solid draw blends toward the source with weight
// E(a)^2, tinted blit scales color by E(tint) and weights by E(tint_a)*E(src_a),
// copy returns the source. The pipe takes one word per clock, sustained while
// out_ready is high, through four register stages: one set-up stage (clip
// compare, tint and weight multipliers), then difference, weighted-step multiply
// and final add stages. Back-pressure on out_ready holds every occupied stage
// in place while empty stages behind it keep filling; the last stage is the
// output register. Config registers (cfg_we, cfg_index, cfg_wdata) are written
// in one clock and should change only while the pipe is empty.
module clipped_tint_alpha_blend_pixel
  import ctab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  // input pixel word
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic signed [15:0] in_dest_x,
  input  logic signed [15:0] in_dest_y,
  input  logic [7:0]        in_src_red,
  input  logic [7:0]        in_src_green,
  input  logic [7:0]        in_src_blue,
  input  logic [7:0]        in_src_alpha,
  input  logic [7:0]        in_dst_red,
  input  logic [7:0]        in_dst_green,
  input  logic [7:0]        in_dst_blue,
  input  logic [7:0]        in_dst_alpha,
  // result word
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic              out_written
);

  localparam logic [2:0] PIPE_DEPTH = 3'd4;

  ctab_cfg_t cfg_r, cfg_nxt;
  logic      s1_valid, s1_ready;
  ctab_pix_t s1_pix;

  // words in flight, for checking only
  logic [2:0] occ_r, occ_nxt;

  // Config write decode; an unused index is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_LEFT:    cfg_nxt.clip_left    = cfg_wdata[15:0];
        REG_CLIP_TOP:     cfg_nxt.clip_top     = cfg_wdata[15:0];
        REG_CLIP_WIDTH:   cfg_nxt.clip_width   = cfg_wdata[15:0];
        REG_CLIP_HEIGHT:  cfg_nxt.clip_height  = cfg_wdata[15:0];
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wdata[14:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_wdata[14:0];
        REG_TINT_COLOR:   cfg_nxt.tint_color   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left    <= RST_CLIP_LEFT;
      cfg_r.clip_top     <= RST_CLIP_TOP;
      cfg_r.clip_width   <= RST_CLIP_WIDTH;
      cfg_r.clip_height  <= RST_CLIP_HEIGHT;
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.tint_color   <= RST_TINT_COLOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ctab_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_dest_x    (in_dest_x),
    .in_dest_y    (in_dest_y),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .in_dst_red   (in_dst_red),
    .in_dst_green (in_dst_green),
    .in_dst_blue  (in_dst_blue),
    .in_dst_alpha (in_dst_alpha),
    .s1_valid     (s1_valid),
    .s1_pix       (s1_pix),
    .s1_ready     (s1_ready)
  );

  ctab_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_pix      (s1_pix),
    .s1_ready    (s1_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_written (out_written)
  );

  always_comb begin
    occ_nxt = occ_r;
    if (in_valid && in_ready) begin
      occ_nxt = occ_nxt + 3'd1;
    end
    if (out_valid && out_ready) begin
      occ_nxt = occ_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // An open output makes every stage ready.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // Never more words in flight than pipe stages.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= PIPE_DEPTH)
    else $error("pipe holds more words than stages");

  // No result without a word in flight.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 3'd0) |-> !out_valid)
    else $error("result word with empty pipe");

  // Reset empties the pipe.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule
